// File: design/lr_pkg.sv
// Shared types and constants for the line rasterizer.
// No dependencies; every other design file refers to this package by scoped names.
package lr_pkg;

    localparam int COORD_BITS  = 16;
    localparam int DELTA_BITS  = COORD_BITS + 1;
    localparam int SCREEN_BITS = 13;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [SCREEN_BITS-1:0] WIDTH_RESET  = SCREEN_BITS'(640);
    localparam logic [SCREEN_BITS-1:0] HEIGHT_RESET = SCREEN_BITS'(320);

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_STEP = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        CFG_DOTTED = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                         func;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic                         draw_enable;
        logic                         in_bounds;
        logic                         last_pixel;
        logic                         all_ok;
    } t_out_item;

    // Classified command handed from front to back.
    typedef struct packed {
        logic                  is_load;
        logic                  major_is_y;
        logic                  minor_neg;
        logic [COORD_BITS-1:0] org_major;
        logic [COORD_BITS-1:0] org_minor;
        logic [DELTA_BITS-1:0] delta_major;
        logic [DELTA_BITS-1:0] delta_minor;
    } t_cmd;

    typedef struct packed {
        logic                   dotted_mode;
        logic [SCREEN_BITS-1:0] screen_width;
        logic [SCREEN_BITS-1:0] screen_height;
    } t_cfg;

endpackage

// File: design/lr_front.sv
// Front end: accepts input items and classifies loads into major/minor axis setup.
// Depends on lr_pkg.
module lr_front (
    input  logic             i_valid,
    input  lr_pkg::t_in_item i_item,
    input  logic             i_full,
    output logic             o_ready,
    output logic             o_push,
    output lr_pkg::t_cmd     o_cmd
);

    localparam int CB = lr_pkg::COORD_BITS;
    localparam int DW = lr_pkg::DELTA_BITS;

    logic [DW-1:0] dx;
    logic [DW-1:0] dy;
    logic [DW-1:0] adx;
    logic [DW-1:0] ady;
    logic [DW-1:0] dmin;
    logic          major_is_y;
    logic          swap;

    always_comb begin
        dx = {i_item.end_x[CB-1], i_item.end_x} - {i_item.start_x[CB-1], i_item.start_x};
        dy = {i_item.end_y[CB-1], i_item.end_y} - {i_item.start_y[CB-1], i_item.start_y};
        adx = dx[DW-1] ? (~dx + DW'(1)) : dx;
        ady = dy[DW-1] ? (~dy + DW'(1)) : dy;
        major_is_y = (dx == '0) || (ady > adx);
        swap = major_is_y ? dy[DW-1] : dx[DW-1];
        dmin = major_is_y ? dx : dy;

        o_cmd.is_load     = (i_item.func == lr_pkg::FUNC_LOAD);
        o_cmd.major_is_y  = major_is_y;
        o_cmd.minor_neg   = (dmin != '0) && (dmin[DW-1] ^ swap);
        o_cmd.org_major   = major_is_y ? (swap ? i_item.end_y : i_item.start_y)
                                       : (swap ? i_item.end_x : i_item.start_x);
        o_cmd.org_minor   = major_is_y ? (swap ? i_item.end_x : i_item.start_x)
                                       : (swap ? i_item.end_y : i_item.start_y);
        o_cmd.delta_major = major_is_y ? ady : adx;
        o_cmd.delta_minor = major_is_y ? adx : ady;
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

endmodule

// File: design/lr_queue.sv
// Short command queue between front and back ends.
// Depends on lr_pkg for the command type.
module lr_queue #(
    parameter int DEPTH = lr_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  lr_pkg::t_cmd i_data,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_valid,
    output lr_pkg::t_cmd o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lr_pkg::t_cmd  r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;

    always_comb begin
        n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: design/lr_back.sv
// Back end: holds the active line, steps it with an incremental error term,
// and drives the output register. Depends on lr_pkg.
module lr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lr_pkg::t_cfg      i_cfg,
    input  logic              i_q_valid,
    input  lr_pkg::t_cmd      i_cmd,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output lr_pkg::t_out_item o_item
);

    localparam int CB   = lr_pkg::COORD_BITS;
    localparam int DW   = lr_pkg::DELTA_BITS;
    localparam int EW   = DW + 2;
    localparam int CMPW = (CB > lr_pkg::SCREEN_BITS) ? CB : lr_pkg::SCREEN_BITS;

    logic              r_active;
    logic              r_ok;
    logic              r_o_valid;
    lr_pkg::t_out_item r_o_item;
    logic [CB-1:0]     r_maj;
    logic [CB-1:0]     r_min;
    logic [EW-1:0]     r_err;
    logic [DW:0]       r_a2;
    logic [DW:0]       r_b2;
    logic [DW-1:0]     r_left;
    logic              r_major_is_y;
    logic              r_neg;
    logic              r_dot_ok;

    logic [CB-1:0]     px;
    logic [CB-1:0]     py;
    logic [CB:0]       sum;
    logic              drawn;
    logic              inb;
    logic              last;
    logic              bad;
    logic [EW-1:0]     e_add;
    logic [EW-1:0]     e_sub;
    logic              carry;
    logic              pop;
    logic              do_step;

    always_comb begin
        px    = r_major_is_y ? r_min : r_maj;
        py    = r_major_is_y ? r_maj : r_min;
        sum   = {px[CB-1], px} + {py[CB-1], py};
        drawn = !(i_cfg.dotted_mode && r_dot_ok) || (!sum[CB] && sum[0]);
        inb   = !px[CB-1] && !py[CB-1]
                && (CMPW'(px) < CMPW'(i_cfg.screen_width))
                && (CMPW'(py) < CMPW'(i_cfg.screen_height));
        bad   = drawn && !inb;
        last  = (r_left == '0);
        e_add = r_err + EW'(r_a2);
        carry = (e_add >= EW'(r_b2));
        e_sub = e_add - EW'(r_b2);
        pop   = i_q_valid && (!r_o_valid || i_ready);
        do_step = pop && !i_cmd.is_load && r_active;
    end

    assign o_pop   = pop;
    assign o_valid = r_o_valid;
    assign o_item  = r_o_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_ok      <= 1'b1;
            r_o_valid <= 1'b0;
        end else begin
            if (do_step) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (pop && i_cmd.is_load) begin
                r_active <= 1'b1;
                r_ok     <= 1'b1;
            end else if (do_step) begin
                r_ok <= r_ok && !bad;
                if (last) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_cmd.is_load) begin
            r_maj        <= i_cmd.org_major;
            r_min        <= i_cmd.org_minor;
            r_err        <= EW'(i_cmd.delta_major);
            r_a2         <= {i_cmd.delta_minor, 1'b0};
            r_b2         <= {i_cmd.delta_major, 1'b0};
            r_left       <= i_cmd.delta_major;
            r_major_is_y <= i_cmd.major_is_y;
            r_neg        <= i_cmd.minor_neg;
            r_dot_ok     <= (i_cmd.delta_major != '0);
        end else if (do_step) begin
            r_o_item.pixel_x     <= px;
            r_o_item.pixel_y     <= py;
            r_o_item.draw_enable <= drawn;
            r_o_item.in_bounds   <= inb;
            r_o_item.last_pixel  <= last;
            r_o_item.all_ok      <= last && r_ok && !bad;
            r_maj  <= r_maj + CB'(1);
            r_left <= r_left - DW'(1);
            r_err  <= carry ? e_sub : e_add;
            if (carry) begin
                r_min <= r_neg ? (r_min - CB'(1)) : (r_min + CB'(1));
            end
        end
    end

endmodule

// File: design/line_rasterizer.sv
// Line rasterizer top level: configuration registers, front end, queue, back end.
// Depends on lr_pkg, lr_front, lr_queue and lr_back.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_in_item): a load item (func 0)
//   gives two endpoints and yields no result; each step item (func 1) yields
//   the next pixel of the loaded line, last_pixel marking the final one.
//   A step with no active line yields nothing.
//   Output channel (o_out_valid/i_out_ready, o_out_item): one pixel per item.
//   Config port (i_cfg_we, i_cfg_idx, i_cfg_data): index 0 dotted mode,
//   1 screen width, 2 screen height; write only while the block is idle.
//   Path: a step item is held in the queue, then in the output register.
//   Throughput: one item per cycle while the output is not stalled, set by the
//   error-term update in the back end; the queue lets the front keep accepting
//   up to QUEUE_DEPTH items while the output is stalled.
//   Reset: no line active, queue empty, registers at 0 / 640 / 320.
//   Stall: the output register holds its pixel until taken; the back end
//   stops, the queue fills, then o_in_ready drops.
module line_rasterizer #(
    parameter int QUEUE_DEPTH = lr_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  lr_pkg::t_in_item              i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output lr_pkg::t_out_item             o_out_item,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [lr_pkg::SCREEN_BITS-1:0] i_cfg_data
);

    lr_pkg::t_cfg r_cfg;
    lr_pkg::t_cmd front_cmd;
    lr_pkg::t_cmd q_cmd;
    logic         push;
    logic         pop;
    logic         q_full;
    logic         q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dotted_mode   <= 1'b0;
            r_cfg.screen_width  <= lr_pkg::WIDTH_RESET;
            r_cfg.screen_height <= lr_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (lr_pkg::t_cfg_idx'(i_cfg_idx))
                lr_pkg::CFG_DOTTED: begin
                    r_cfg.dotted_mode <= i_cfg_data[0];
                end
                lr_pkg::CFG_WIDTH: begin
                    r_cfg.screen_width <= i_cfg_data;
                end
                lr_pkg::CFG_HEIGHT: begin
                    r_cfg.screen_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    lr_front u_front (
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .i_full  (q_full),
        .o_ready (o_in_ready),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    lr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    lr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_item    (o_out_item)
    );

    a_ok_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.all_ok |-> o_out_item.last_pixel)
        else $error("all_ok set on a pixel that is not the last");

    a_ok_drawn_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.all_ok && o_out_item.draw_enable
        |-> o_out_item.in_bounds)
        else $error("all_ok set on a drawn pixel outside the screen");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output valid or input stalled right after reset");

endmodule

// File: sim/lr_pixel_checker.sv
// Pixel checker for the line rasterizer: follows loads, steps and register writes,
// predicts each pixel and compares it with the pixel taken from the output channel.
// Depends on lr_pkg.
module lr_pixel_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  lr_pkg::t_in_item              i_in_item,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  lr_pkg::t_out_item             i_out_item,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [lr_pkg::SCREEN_BITS-1:0] i_cfg_data,
    output int                            o_pending,
    output int                            o_fail_count
);
    import lr_pkg::*;

    t_cfg                         cfg;
    logic signed [COORD_BITS-1:0] org_x;
    logic signed [COORD_BITS-1:0] org_y;
    logic [DELTA_BITS-1:0]        span_major;
    logic [DELTA_BITS-1:0]        span_minor;
    logic [DELTA_BITS-1:0]        step_idx;
    int                           minor_dir;
    logic                         major_y;
    logic                         line_on;
    logic                         bounds_ok;
    t_out_item                    expected_pixels[$];
    int                           fails;

    task automatic load_line(input t_in_item it);
        longint x0, y0, x1, y1, adx, ady, tmp, dmin;
        x0 = longint'($signed(it.start_x));
        y0 = longint'($signed(it.start_y));
        x1 = longint'($signed(it.end_x));
        y1 = longint'($signed(it.end_y));
        adx = x1 > x0 ? x1 - x0 : x0 - x1;
        ady = y1 > y0 ? y1 - y0 : y0 - y1;
        major_y = !(x1 != x0 && ady <= adx);
        if (major_y ? (y0 > y1) : (x0 > x1)) begin
            tmp = x0; x0 = x1; x1 = tmp;
            tmp = y0; y0 = y1; y1 = tmp;
        end
        org_x = x0[COORD_BITS-1:0];
        org_y = y0[COORD_BITS-1:0];
        tmp = major_y ? y1 - y0 : x1 - x0;
        span_major = tmp[DELTA_BITS-1:0];
        dmin = major_y ? x1 - x0 : y1 - y0;
        minor_dir = dmin > 0 ? 1 : (dmin < 0 ? -1 : 0);
        if (dmin < 0)
            dmin = -dmin;
        span_minor = dmin[DELTA_BITS-1:0];
        step_idx = '0;
        line_on = 1'b1;
        bounds_ok = 1'b1;
    endtask

    function automatic t_out_item predict_pixel();
        longint    k, prod, q, major, minor, px, py, sum;
        logic      drawn, inb, last;
        t_out_item pix;
        k = longint'(step_idx);
        q = 0;
        if (span_major != 0) begin
            prod = longint'(span_minor) * k;
            q = prod / longint'(span_major);
            if (2 * (prod % longint'(span_major)) >= longint'(span_major))
                q = q + 1;
        end
        major = (major_y ? longint'(org_y) : longint'(org_x)) + k;
        minor = (major_y ? longint'(org_x) : longint'(org_y)) + minor_dir * q;
        px = major_y ? minor : major;
        py = major_y ? major : minor;
        sum = px + py;
        drawn = (cfg.dotted_mode && span_major != 0) ? (sum > 0 && sum[0]) : 1'b1;
        inb = px >= 0 && py >= 0 && px < longint'(cfg.screen_width)
              && py < longint'(cfg.screen_height);
        if (drawn && !inb)
            bounds_ok = 1'b0;
        last = k >= longint'(span_major);
        pix.pixel_x = px[COORD_BITS-1:0];
        pix.pixel_y = py[COORD_BITS-1:0];
        pix.draw_enable = drawn;
        pix.in_bounds = inb;
        pix.last_pixel = last;
        pix.all_ok = last && bounds_ok;
        if (last)
            line_on = 1'b0;
        else
            step_idx = step_idx + 1'b1;
        return pix;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            cfg.dotted_mode = 1'b0;
            cfg.screen_width = WIDTH_RESET;
            cfg.screen_height = HEIGHT_RESET;
            org_x = '0;
            org_y = '0;
            span_major = '0;
            span_minor = '0;
            step_idx = '0;
            minor_dir = 0;
            major_y = 1'b0;
            line_on = 1'b0;
            bounds_ok = 1'b1;
            expected_pixels.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_DOTTED: cfg.dotted_mode = i_cfg_data[0];
                    CFG_WIDTH: cfg.screen_width = i_cfg_data;
                    CFG_HEIGHT: cfg.screen_height = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_item.func == FUNC_LOAD)
                    load_line(i_in_item);
                else if (line_on)
                    expected_pixels.push_back(predict_pixel());
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected pixel x=%0d y=%0d",
                                 i_out_item.pixel_x, i_out_item.pixel_y);
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_out_item.pixel_x !== want.pixel_x
                        || i_out_item.pixel_y !== want.pixel_y
                        || i_out_item.draw_enable !== want.draw_enable
                        || i_out_item.in_bounds !== want.in_bounds
                        || i_out_item.last_pixel !== want.last_pixel
                        || i_out_item.all_ok !== want.all_ok) begin
                        fails++;
                        if (fails <= 10)
                            $display({"pixel check failed: want x=%0d y=%0d draw=%0b inb=%0b",
                                      " last=%0b ok=%0b, got x=%0d y=%0d draw=%0b inb=%0b",
                                      " last=%0b ok=%0b"},
                                     want.pixel_x, want.pixel_y, want.draw_enable,
                                     want.in_bounds, want.last_pixel, want.all_ok,
                                     i_out_item.pixel_x, i_out_item.pixel_y,
                                     i_out_item.draw_enable, i_out_item.in_bounds,
                                     i_out_item.last_pixel, i_out_item.all_ok);
                    end
                end
            end
        end
        o_pending <= expected_pixels.size();
        o_fail_count <= fails;
    end

endmodule

// File: sim/tb_line_rasterizer.sv
// Testbench top for the line rasterizer: drives loads, steps and register writes
// under varying back-pressure and reports the verdict.
// Depends on lr_pkg, line_rasterizer and lr_pixel_checker.
module tb_line_rasterizer;
    import lr_pkg::*;

    localparam int ITEMS_PER_PHASE = 300;
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_CYCLES     = 60;
    localparam int WATCHDOG_LIMIT  = 4000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    t_in_item               in_item = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    t_out_item              out_item;
    logic                   cfg_we = 1'b0;
    logic [1:0]             cfg_idx = CFG_DOTTED;
    logic [SCREEN_BITS-1:0] cfg_data = '0;
    int                     pending;
    int                     fail_count;
    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;
    int                     items_sent = 0;
    int                     stall_cycles = 0;
    bit                     hold_req = 1'b0;

    line_rasterizer u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    lr_pixel_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("line_rasterizer: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic t_in_item load_item(input int sx, input int sy,
                                           input int ex, input int ey);
        t_in_item it;
        it.func = FUNC_LOAD;
        it.start_x = COORD_BITS'(sx);
        it.start_y = COORD_BITS'(sy);
        it.end_x = COORD_BITS'(ex);
        it.end_y = COORD_BITS'(ey);
        return it;
    endfunction

    function automatic t_in_item step_item();
        t_in_item it;
        it.func = FUNC_STEP;
        it.start_x = COORD_BITS'($urandom);
        it.start_y = COORD_BITS'($urandom);
        it.end_x = COORD_BITS'($urandom);
        it.end_y = COORD_BITS'($urandom);
        return it;
    endfunction

    function automatic int line_span(input int sx, input int sy, input int ex, input int ey);
        int adx, ady;
        adx = ex > sx ? ex - sx : sx - ex;
        ady = ey > sy ? ey - sy : sy - ey;
        return (adx > ady ? adx : ady) + 1;
    endfunction

    task automatic send_item(input t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
    endtask

    task automatic wait_idle(input bit settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input bit dotted, input int width, input int height);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_DOTTED;
        cfg_data <= SCREEN_BITS'(dotted);
        @(posedge clk);
        cfg_idx <= CFG_WIDTH;
        cfg_data <= SCREEN_BITS'(width);
        @(posedge clk);
        cfg_idx <= CFG_HEIGHT;
        cfg_data <= SCREEN_BITS'(height);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_line(input int sx, input int sy, input int ex, input int ey,
                            input int n_steps, input int n_noise);
        send_item(load_item(sx, sy, ex, ey));
        items_sent++;
        repeat (n_steps) begin
            send_item(step_item());
            items_sent++;
        end
        repeat (n_noise) send_item(step_item());
    endtask

    task automatic directed_lines();
        send_item(step_item());                             // no line loaded yet
        run_line(5, 5, 5, 5, 1, 0);                         // single point
        run_line(4, 1, 0, 3, line_span(4, 1, 0, 3), 0);     // reversed, exact halves
        run_line(0, 0, -1, 2, line_span(0, 0, -1, 2), 0);   // y major, minor falling
        run_line(-32768, -32768, 32767, 32767, 2, 0);       // cut short by next load
        run_line(32767, -32768, -32768, 32767, 2, 0);
        run_line(639, 319, 640, 320, line_span(639, 319, 640, 320), 1);
    endtask

    task automatic random_line();
        int sx, sy, ex, ey, d, kind, span, n, noise;
        kind = $urandom_range(0, 99);
        sx = int'($urandom_range(0, 760)) - 60;
        sy = int'($urandom_range(0, 440)) - 60;
        if (kind < 60) begin
            ex = sx + int'($urandom_range(0, 24)) - 12;
            ey = sy + int'($urandom_range(0, 24)) - 12;
        end else if (kind < 72) begin
            ex = sx + int'($urandom_range(0, 300)) - 150;
            ey = sy + int'($urandom_range(0, 300)) - 150;
        end else if (kind < 84) begin
            d = $urandom_range(1, 12);
            case ($urandom_range(0, 4))
                0: begin ex = sx; ey = sy; end
                1: begin ex = sx - d; ey = sy; end
                2: begin ex = sx; ey = sy + d; end
                3: begin ex = sx + d; ey = sy - d; end
                default: begin ex = sx - 2 * d; ey = sy + d; end
            endcase
        end else if (kind < 92) begin
            sx = int'($urandom_range(0, 65535)) - 32768;
            sy = int'($urandom_range(0, 65535)) - 32768;
            ex = int'($urandom_range(0, 65535)) - 32768;
            ey = int'($urandom_range(0, 65535)) - 32768;
        end else begin
            if ($urandom_range(0, 1)) begin
                sx = 32767 - int'($urandom_range(0, 15));
                ex = 32767 - int'($urandom_range(0, 15));
            end else begin
                sx = -32768 + int'($urandom_range(0, 15));
                ex = -32768 + int'($urandom_range(0, 15));
            end
            if ($urandom_range(0, 1)) begin
                sy = 32767 - int'($urandom_range(0, 15));
                ey = 32767 - int'($urandom_range(0, 15));
            end else begin
                sy = -32768 + int'($urandom_range(0, 15));
                ey = -32768 + int'($urandom_range(0, 15));
            end
        end
        span = line_span(sx, sy, ex, ey);
        if (span > 200)
            n = $urandom_range(0, 48);
        else if ($urandom_range(0, 9) == 0)
            n = $urandom_range(0, span - 1);
        else
            n = span;
        noise = (n == span && $urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
        run_line(sx, sy, ex, ey, n, noise);
    endtask

    task automatic run_phase(input bit dotted, input int width, input int height,
                             input int sender_pct, input int receiver_pct,
                             input bit with_hold, input bit with_directed);
        int phase_goal;
        wait_idle(1'b1);
        set_config(dotted, width, height);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        if (with_directed)
            directed_lines();
        if (with_hold) begin
            hold_req = 1'b1;
            run_line(0, 0, 40, 7, line_span(0, 0, 40, 7), 0);
        end
        phase_goal = items_sent + ITEMS_PER_PHASE;
        while (items_sent < phase_goal) begin
            random_line();
            if ($urandom_range(0, 39) == 0)
                wait_idle(1'b0);
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        run_phase(1'b0, 640, 320, 30, 81, 1'b1, 1'b1);
        run_phase(1'b1, 4096, 4096, 30, 81, 1'b0, 1'b0);
        run_phase(1'b1, 0, 0, 81, 30, 1'b0, 1'b0);
        run_phase(1'b0, 8191, 1, 81, 30, 1'b1, 1'b0);
        run_phase(1'b1, 1, 8191, 0, 0, 1'b0, 1'b0);
        run_phase(1'($urandom_range(0, 1)), $urandom_range(1, 4096), $urandom_range(1, 4096),
                  0, 0, 1'b1, 1'b0);
        wait_idle(1'b1);
        if (fail_count == 0 && pending == 0)
            $display("line_rasterizer: match");
        else
            $display("line_rasterizer: mismatch");
        $finish;
    end

endmodule
